/* rtl/pcne_pkg.sv */
// ----------------------------------------------------------------------------
// pcne_pkg
// Shared types and constants of the point cloud normal estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcne_pkg;

    // normalized magnitude, square, sum and root widths
    localparam int A_W   = 30;
    localparam int SQ_W  = 2 * A_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int Q_W   = SUM_W / 2;
    // unit component magnitude, divisor and dividend widths
    localparam int U_W   = 15;
    localparam int D_W   = Q_W + 1;
    localparam int N_W   = A_W + U_W + 1;
    localparam int OUT_W = U_W + 1;

    localparam int ROW_W = 10;
    localparam int CFG_W = 11;

    // lane order of a packed point {x, y, z}
    localparam int LX = 2;
    localparam int LY = 1;
    localparam int LZ = 0;

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [CFG_W-1:0] MIN_DIM    = 11'd3;
    localparam logic [CFG_W-1:0] MAX_HEIGHT = 11'd1024;

    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
    } t_tag;

    typedef struct packed {
        logic [A_W-1:0] ax;
        logic [A_W-1:0] ay;
        logic [A_W-1:0] az;
    } t_avec;

endpackage

`default_nettype wire

/* rtl/pcne_linebuf.sv */
// ----------------------------------------------------------------------------
// pcne_linebuf
// Two line buffers in one memory and the diagonal corner window.
// ----------------------------------------------------------------------------
`default_nettype none

module pcne_linebuf #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  COORD_BITS = 16,
    localparam int AW         = $clog2(MAX_WIDTH),
    localparam int PW         = 3 * COORD_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_acc,
    input  wire logic [AW-1:0]  i_addr,
    input  wire logic [PW-1:0]  i_pt,
    input  pcne_pkg::t_tag      i_tag,
    output logic                o_vld,
    output pcne_pkg::t_tag      o_tag,
    output logic [PW-1:0]       o_tl,
    output logic [PW-1:0]       o_tr,
    output logic [PW-1:0]       o_dl,
    output logic [PW-1:0]       o_dr
);

    logic [2*PW-1:0] r_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd;

    logic            r_s1_vld;
    logic [AW-1:0]   r_s1_addr;
    logic [PW-1:0]   r_s1_pt;
    pcne_pkg::t_tag  r_s1_tag;

    logic            r_lw_vld;
    logic [AW-1:0]   r_lw_addr;
    logic [2*PW-1:0] r_lw_data;

    logic [PW-1:0]   r_w0, r_w1, r_w4, r_w5;

    logic [2*PW-1:0] rd_fwd;
    logic [2*PW-1:0] wr_data;
    logic [PW-1:0]   top_pt;
    logic [PW-1:0]   mid_pt;

    // forward the write that landed with this read
    always_comb begin
        rd_fwd  = (r_lw_vld && (r_lw_addr == r_s1_addr)) ? r_lw_data : r_rd;
        top_pt  = rd_fwd[2*PW-1:PW];
        mid_pt  = rd_fwd[PW-1:0];
        wr_data = {mid_pt, r_s1_pt};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= r_mem[i_addr];
            if (r_s1_vld) begin
                r_mem[r_s1_addr] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_lw_vld <= 1'b0;
            o_vld    <= 1'b0;
            r_w0     <= '0;
            r_w1     <= '0;
            r_w4     <= '0;
            r_w5     <= '0;
        end else if (i_en) begin
            r_s1_vld <= i_acc;
            r_lw_vld <= r_s1_vld;
            o_vld    <= r_s1_vld;
            if (r_s1_vld) begin
                r_w0 <= top_pt;
                r_w1 <= r_w0;
                r_w4 <= r_s1_pt;
                r_w5 <= r_w4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_addr <= i_addr;
            r_s1_pt   <= i_pt;
            r_s1_tag  <= i_tag;
            r_lw_addr <= r_s1_addr;
            r_lw_data <= wr_data;
            o_tag     <= r_s1_tag;
            o_tl      <= r_w1;
            o_tr      <= top_pt;
            o_dl      <= r_w5;
            o_dr      <= r_s1_pt;
        end
    end

endmodule

`default_nettype wire

/* rtl/pcne_cross.sv */
// ----------------------------------------------------------------------------
// pcne_cross
// Diagonal differences, cross product, range reduction and squared norm.
// ----------------------------------------------------------------------------
`default_nettype none

module pcne_cross #(
    parameter int  COORD_BITS = 16,
    localparam int PW         = 3 * COORD_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  pcne_pkg::t_tag     i_tag,
    input  wire logic [PW-1:0] i_tl,
    input  wire logic [PW-1:0] i_tr,
    input  wire logic [PW-1:0] i_dl,
    input  wire logic [PW-1:0] i_dr,
    output logic               o_vld,
    output pcne_pkg::t_tag     o_tag,
    output pcne_pkg::t_avec    o_av,
    output logic [pcne_pkg::SUM_W-1:0] o_sum
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int PRW = 2 * DW;
    localparam int XW  = PRW + 1;
    localparam int MW  = XW - 1;
    localparam int TW  = (MW > pcne_pkg::A_W) ? MW : pcne_pkg::A_W;
    localparam int SW  = $clog2(MW + 1);

    logic [7:0] r_v;

    // stage 1: differences
    logic signed [DW-1:0] n1_a [3];
    logic signed [DW-1:0] n1_b [3];
    logic signed [DW-1:0] r1_a [3];
    logic signed [DW-1:0] r1_b [3];
    pcne_pkg::t_tag       n1_tag, r1_tag;

    // stage 2: products
    logic signed [PRW-1:0] n2_p [6];
    logic signed [PRW-1:0] r2_p [6];
    pcne_pkg::t_tag        r2_tag;

    // stage 3: cross product
    logic signed [XW-1:0] r3_cx, r3_cy, r3_cz;
    pcne_pkg::t_tag       r3_tag;

    // stage 4: magnitudes
    logic [MW-1:0]  r4_mx, r4_my, r4_mz;
    pcne_pkg::t_tag n4_tag, r4_tag;

    // stage 5: largest magnitude
    logic [MW-1:0]  n5_m;
    logic [MW-1:0]  r5_m, r5_mx, r5_my, r5_mz;
    pcne_pkg::t_tag r5_tag;

    // stage 6: shift into range
    logic [SW-1:0]   n6_s;
    logic [TW-1:0]   n6_tx, n6_ty, n6_tz;
    pcne_pkg::t_tag  n6_tag, r6_tag;
    pcne_pkg::t_avec r6_av;

    // stage 7: squares
    logic [pcne_pkg::SQ_W-1:0] r7_sx, r7_sy, r7_sz;
    pcne_pkg::t_tag            r7_tag;
    pcne_pkg::t_avec           r7_av;

    always_comb begin
        n1_tag       = i_tag;
        n1_tag.zero  = (i_tl == '0) || (i_tr == '0) || (i_dl == '0) || (i_dr == '0);
        n1_tag.neg_x = 1'b0;
        n1_tag.neg_y = 1'b0;
        for (int j = 0; j < 3; j++) begin
            n1_a[j] = DW'($signed(i_tl[j*CB +: CB])) - DW'($signed(i_dr[j*CB +: CB]));
            n1_b[j] = DW'($signed(i_tr[j*CB +: CB])) - DW'($signed(i_dl[j*CB +: CB]));
        end
    end

    always_comb begin
        n2_p[0] = r1_a[pcne_pkg::LY] * r1_b[pcne_pkg::LZ];
        n2_p[1] = r1_a[pcne_pkg::LZ] * r1_b[pcne_pkg::LY];
        n2_p[2] = r1_a[pcne_pkg::LZ] * r1_b[pcne_pkg::LX];
        n2_p[3] = r1_a[pcne_pkg::LX] * r1_b[pcne_pkg::LZ];
        n2_p[4] = r1_a[pcne_pkg::LX] * r1_b[pcne_pkg::LY];
        n2_p[5] = r1_a[pcne_pkg::LY] * r1_b[pcne_pkg::LX];
    end

    always_comb begin
        n4_tag       = r3_tag;
        n4_tag.neg_x = r3_cx[XW-1] ^ r3_cz[XW-1];
        n4_tag.neg_y = r3_cy[XW-1] ^ r3_cz[XW-1];
    end

    always_comb begin
        n5_m = r4_mx;
        if (r4_my > n5_m) begin
            n5_m = r4_my;
        end
        if (r4_mz > n5_m) begin
            n5_m = r4_mz;
        end
    end

    always_comb begin
        n6_s = '0;
        for (int j = pcne_pkg::A_W; j < MW; j++) begin
            if ((r5_m >> j) != '0) begin
                n6_s = n6_s + 1'b1;
            end
        end
        n6_tx       = TW'(r5_mx) >> n6_s;
        n6_ty       = TW'(r5_my) >> n6_s;
        n6_tz       = TW'(r5_mz) >> n6_s;
        n6_tag      = r5_tag;
        n6_tag.zero = r5_tag.zero || (r5_m == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= n1_a;
            r1_b   <= n1_b;
            r1_tag <= n1_tag;

            r2_p   <= n2_p;
            r2_tag <= r1_tag;

            r3_cx  <= XW'(r2_p[0]) - XW'(r2_p[1]);
            r3_cy  <= XW'(r2_p[2]) - XW'(r2_p[3]);
            r3_cz  <= XW'(r2_p[4]) - XW'(r2_p[5]);
            r3_tag <= r2_tag;

            r4_mx  <= r3_cx[XW-1] ? MW'(-r3_cx) : MW'(r3_cx);
            r4_my  <= r3_cy[XW-1] ? MW'(-r3_cy) : MW'(r3_cy);
            r4_mz  <= r3_cz[XW-1] ? MW'(-r3_cz) : MW'(r3_cz);
            r4_tag <= n4_tag;

            r5_m   <= n5_m;
            r5_mx  <= r4_mx;
            r5_my  <= r4_my;
            r5_mz  <= r4_mz;
            r5_tag <= r4_tag;

            r6_av.ax <= n6_tx[pcne_pkg::A_W-1:0];
            r6_av.ay <= n6_ty[pcne_pkg::A_W-1:0];
            r6_av.az <= n6_tz[pcne_pkg::A_W-1:0];
            r6_tag   <= n6_tag;

            r7_sx  <= pcne_pkg::SQ_W'(r6_av.ax) * pcne_pkg::SQ_W'(r6_av.ax);
            r7_sy  <= pcne_pkg::SQ_W'(r6_av.ay) * pcne_pkg::SQ_W'(r6_av.ay);
            r7_sz  <= pcne_pkg::SQ_W'(r6_av.az) * pcne_pkg::SQ_W'(r6_av.az);
            r7_av  <= r6_av;
            r7_tag <= r6_tag;

            o_sum  <= pcne_pkg::SUM_W'(r7_sx) + pcne_pkg::SUM_W'(r7_sy)
                    + pcne_pkg::SUM_W'(r7_sz);
            o_av   <= r7_av;
            o_tag  <= r7_tag;
        end
    end

    assign o_vld = r_v[7];

endmodule

`default_nettype wire

/* rtl/pcne_sqrt.sv */
// ----------------------------------------------------------------------------
// pcne_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pcne_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire logic [pcne_pkg::SUM_W-1:0] i_sum,
    input  pcne_pkg::t_avec                 i_av,
    input  pcne_pkg::t_tag                  i_tag,
    output logic                            o_vld,
    output logic [pcne_pkg::Q_W-1:0]        o_q,
    output pcne_pkg::t_avec                 o_av,
    output pcne_pkg::t_tag                  o_tag
);

    localparam int NS = pcne_pkg::Q_W;
    localparam int XW = pcne_pkg::SUM_W;

    logic [XW-1:0]   r_x   [NS];
    logic [XW-1:0]   r_r   [NS];
    logic            r_v   [NS];
    pcne_pkg::t_avec r_av  [NS];
    pcne_pkg::t_tag  r_tag [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam int            K       = NS - 1 - g;
        localparam logic [XW-1:0] BIT_VAL = XW'(1) << (2 * K);

        logic [XW-1:0]   x_in, r_in;
        logic            v_in;
        pcne_pkg::t_avec av_in;
        pcne_pkg::t_tag  tag_in;
        logic [XW:0]     trial;
        logic [XW-1:0]   n_x, n_r;

        if (g == 0) begin : g_head
            assign x_in   = i_sum;
            assign r_in   = '0;
            assign v_in   = i_vld;
            assign av_in  = i_av;
            assign tag_in = i_tag;
        end else begin : g_body
            assign x_in   = r_x[g-1];
            assign r_in   = r_r[g-1];
            assign v_in   = r_v[g-1];
            assign av_in  = r_av[g-1];
            assign tag_in = r_tag[g-1];
        end

        always_comb begin
            trial = {1'b0, r_in} + {1'b0, BIT_VAL};
            if ({1'b0, x_in} >= trial) begin
                n_x = x_in - XW'(trial);
                n_r = (r_in >> 1) + BIT_VAL;
            end else begin
                n_x = x_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]   <= n_x;
                r_r[g]   <= n_r;
                r_av[g]  <= av_in;
                r_tag[g] <= tag_in;
            end
        end
    end

    assign o_vld = r_v[NS-1];
    assign o_q   = r_r[NS-1][pcne_pkg::Q_W-1:0];
    assign o_av  = r_av[NS-1];
    assign o_tag = r_tag[NS-1];

endmodule

`default_nettype wire

/* rtl/pcne_div.sv */
// ----------------------------------------------------------------------------
// pcne_div
// Three pipelined restoring dividers: round(a * 16384 / q), one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pcne_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire logic [pcne_pkg::Q_W-1:0] i_q,
    input  pcne_pkg::t_avec               i_av,
    input  pcne_pkg::t_tag                i_tag,
    output logic                          o_vld,
    output logic [pcne_pkg::U_W-1:0]      o_ux,
    output logic [pcne_pkg::U_W-1:0]      o_uy,
    output logic [pcne_pkg::U_W-1:0]      o_uz,
    output pcne_pkg::t_tag                o_tag
);

    localparam int NS = pcne_pkg::U_W;
    localparam int NW = pcne_pkg::N_W;
    localparam int DW = pcne_pkg::D_W;

    // setup stage: dividend a * 32768 + q, divisor 2q
    logic           r0_v;
    logic [NW-1:0]  r0_n [3];
    logic [DW-1:0]  r0_d;
    pcne_pkg::t_tag r0_tag;

    logic [NW-1:0]   r_rem [NS][3];
    logic [NS-1:0]   r_quo [NS][3];
    logic [DW-1:0]   r_d   [NS];
    logic            r_v   [NS];
    pcne_pkg::t_tag  r_tag [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_n[0] <= (NW'(i_av.ax) << pcne_pkg::U_W) + NW'(i_q);
            r0_n[1] <= (NW'(i_av.ay) << pcne_pkg::U_W) + NW'(i_q);
            r0_n[2] <= (NW'(i_av.az) << pcne_pkg::U_W) + NW'(i_q);
            r0_d    <= {i_q, 1'b0};
            r0_tag  <= i_tag;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam int K = NS - 1 - g;

        logic [NW-1:0]  rem_in [3];
        logic [NS-1:0]  quo_in [3];
        logic [DW-1:0]  d_in;
        logic           v_in;
        pcne_pkg::t_tag tag_in;
        logic [NW-1:0]  sub;
        logic [NW-1:0]  n_rem [3];
        logic [NS-1:0]  n_quo [3];

        if (g == 0) begin : g_head
            assign rem_in = r0_n;
            assign quo_in = '{default: '0};
            assign d_in   = r0_d;
            assign v_in   = r0_v;
            assign tag_in = r0_tag;
        end else begin : g_body
            assign rem_in = r_rem[g-1];
            assign quo_in = r_quo[g-1];
            assign d_in   = r_d[g-1];
            assign v_in   = r_v[g-1];
            assign tag_in = r_tag[g-1];
        end

        always_comb begin
            sub = NW'(d_in) << K;
            for (int j = 0; j < 3; j++) begin
                if (rem_in[j] >= sub) begin
                    n_rem[j] = rem_in[j] - sub;
                    n_quo[j] = {quo_in[j][NS-2:0], 1'b1};
                end else begin
                    n_rem[j] = rem_in[j];
                    n_quo[j] = {quo_in[j][NS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_quo[g] <= n_quo;
                r_d[g]   <= d_in;
                r_tag[g] <= tag_in;
            end
        end
    end

    assign o_vld = r_v[NS-1];
    assign o_ux  = r_quo[NS-1][0];
    assign o_uy  = r_quo[NS-1][1];
    assign o_uz  = r_quo[NS-1][2];
    assign o_tag = r_tag[NS-1];

endmodule

`default_nettype wire

/* rtl/point_cloud_normal_estimator.sv */
// ----------------------------------------------------------------------------
// point_cloud_normal_estimator
// Unit surface normals of an organized point cloud streamed in raster order.
//
//   channel  direction  handshake          payload
//   points   in         i_valid / o_stall  i_point_x/y/z, i_start_of_frame
//   normals  out        o_valid / i_stall  o_normal_x/y/z, o_center_*
//   config   in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One point per cycle while o_stall is low; a normal leaves after the point
// that completes its window has passed the line buffer, cross product, root,
// divide and output registers. Border pixels give no word.
// A stalled output word freezes the whole pipeline, and o_stall follows.
// Reset clears counters, window and valid bits; the line buffer memory is
// not cleared and the block accepts points right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module point_cloud_normal_estimator #(
    parameter int MAX_WIDTH  = 1024,
    parameter int COORD_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [15:0]         i_point_x,
    input  wire logic signed [15:0]         i_point_y,
    input  wire logic signed [15:0]         i_point_z,
    input  wire logic                       i_start_of_frame,

    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [15:0]              o_normal_x,
    output logic signed [15:0]              o_normal_y,
    output logic [14:0]                     o_normal_z,
    output logic                            o_center_valid,
    output logic [9:0]                      o_center_row,
    output logic [9:0]                      o_center_col,

    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [pcne_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int PW = 3 * CB;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WX = ($clog2(MAX_WIDTH + 1) > pcne_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : pcne_pkg::CFG_W;
    localparam int RW = pcne_pkg::ROW_W;
    localparam int HW = pcne_pkg::CFG_W;
    localparam int OW = pcne_pkg::OUT_W;

    logic [HW-1:0] r_cfg_width, r_cfg_height;
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic          en;
    logic          acc;
    logic [AW-1:0] c_eff;
    logic [RW-1:0] r_eff;
    logic [WX-1:0] w_eff, col_x, col_nx;
    logic [HW-1:0] h_eff, row_x, row_nx;
    logic          wrap;
    logic [AW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [PW-1:0] pt;
    logic [WX-1:0] col_m1;
    pcne_pkg::t_tag tag_in;

    logic            lb_vld;
    pcne_pkg::t_tag  lb_tag;
    logic [PW-1:0]   lb_tl, lb_tr, lb_dl, lb_dr;

    logic                       cr_vld;
    pcne_pkg::t_tag             cr_tag;
    pcne_pkg::t_avec            cr_av;
    logic [pcne_pkg::SUM_W-1:0] cr_sum;

    logic                     sq_vld;
    logic [pcne_pkg::Q_W-1:0] sq_q;
    pcne_pkg::t_avec          sq_av;
    pcne_pkg::t_tag           sq_tag;

    logic                     dv_vld;
    logic [pcne_pkg::U_W-1:0] dv_ux, dv_uy, dv_uz;
    pcne_pkg::t_tag           dv_tag;

    logic [OW-1:0] n_nx, n_ny;
    logic [14:0]   n_nz;

    // advance unless the output word is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign acc     = i_valid && en;

    always_comb begin
        w_eff = WX'(r_cfg_width);
        if (r_cfg_width < pcne_pkg::MIN_DIM) begin
            w_eff = WX'(pcne_pkg::MIN_DIM);
        end else if (WX'(r_cfg_width) > WX'(MAX_WIDTH)) begin
            w_eff = WX'(MAX_WIDTH);
        end
        h_eff = r_cfg_height;
        if (r_cfg_height < pcne_pkg::MIN_DIM) begin
            h_eff = pcne_pkg::MIN_DIM;
        end else if (r_cfg_height > pcne_pkg::MAX_HEIGHT) begin
            h_eff = pcne_pkg::MAX_HEIGHT;
        end

        c_eff  = i_start_of_frame ? '0 : r_col;
        r_eff  = i_start_of_frame ? '0 : r_row;
        col_x  = WX'(c_eff);
        row_x  = HW'(r_eff);
        col_nx = col_x + 1'b1;
        row_nx = row_x + 1'b1;
        wrap   = (col_nx >= w_eff);
        n_col  = wrap ? '0 : col_nx[AW-1:0];
        n_row  = r_eff;
        if (wrap) begin
            n_row = (row_nx >= h_eff) ? '0 : row_nx[RW-1:0];
        end

        col_m1       = col_x - 1'b1;
        tag_in.emit  = (r_eff >= RW'(2)) && (c_eff >= AW'(2))
                    && (row_x < h_eff) && (col_x < w_eff);
        tag_in.row   = r_eff - 1'b1;
        tag_in.col   = col_m1[RW-1:0];
        tag_in.neg_x = 1'b0;
        tag_in.neg_y = 1'b0;
        tag_in.zero  = 1'b0;

        pt = {CB'($unsigned(i_point_x)), CB'($unsigned(i_point_y)),
              CB'($unsigned(i_point_z))};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= pcne_pkg::WIDTH_RST;
            r_cfg_height <= pcne_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcne_pkg::CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                pcne_pkg::CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    pcne_linebuf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .COORD_BITS (COORD_BITS)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (acc),
        .i_addr  (c_eff),
        .i_pt    (pt),
        .i_tag   (tag_in),
        .o_vld   (lb_vld),
        .o_tag   (lb_tag),
        .o_tl    (lb_tl),
        .o_tr    (lb_tr),
        .o_dl    (lb_dl),
        .o_dr    (lb_dr)
    );

    pcne_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (lb_vld && lb_tag.emit),
        .i_tag   (lb_tag),
        .i_tl    (lb_tl),
        .i_tr    (lb_tr),
        .i_dl    (lb_dl),
        .i_dr    (lb_dr),
        .o_vld   (cr_vld),
        .o_tag   (cr_tag),
        .o_av    (cr_av),
        .o_sum   (cr_sum)
    );

    pcne_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (cr_vld),
        .i_sum   (cr_sum),
        .i_av    (cr_av),
        .i_tag   (cr_tag),
        .o_vld   (sq_vld),
        .o_q     (sq_q),
        .o_av    (sq_av),
        .o_tag   (sq_tag)
    );

    pcne_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_q     (sq_q),
        .i_av    (sq_av),
        .i_tag   (sq_tag),
        .o_vld   (dv_vld),
        .o_ux    (dv_ux),
        .o_uy    (dv_uy),
        .o_uz    (dv_uz),
        .o_tag   (dv_tag)
    );

    always_comb begin
        if (dv_tag.zero) begin
            n_nx = '0;
            n_ny = '0;
            n_nz = '0;
        end else begin
            n_nx = dv_tag.neg_x ? (OW'(0) - OW'(dv_ux)) : OW'(dv_ux);
            n_ny = dv_tag.neg_y ? (OW'(0) - OW'(dv_uy)) : OW'(dv_uy);
            n_nz = dv_uz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_normal_x     <= n_nx;
            o_normal_y     <= n_ny;
            o_normal_z     <= n_nz;
            o_center_valid <= dv_tag.emit;
            o_center_row   <= dv_tag.row;
            o_center_col   <= dv_tag.col;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams organized point clouds through point_cloud_normal_estimator under
// several image sizes, predicts each centre-pixel normal in parallel and
// compares every output word with the oldest predicted normal.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT     = 400000;
    localparam int BUF_DEPTH = 1024;
    localparam int DRAIN     = 100;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_point;

    typedef struct packed {
        t_point pt;
        logic   sof;
    } t_point_word;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [14:0] nz;
        logic [9:0]  row;
        logic [9:0]  col;
    } t_normal;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic signed [15:0] i_point_x = '0;
    logic signed [15:0] i_point_y = '0;
    logic signed [15:0] i_point_z = '0;
    logic              i_start_of_frame = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;
    logic [14:0]       o_normal_z;
    logic              o_center_valid;
    logic [9:0]        o_center_row;
    logic [9:0]        o_center_col;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = pcne_pkg::CFG_WIDTH;
    logic [pcne_pkg::CFG_W-1:0] i_cfg_data = '0;

    point_cloud_normal_estimator DUT (.*);

    always #5 i_clk = ~i_clk;

    t_point_word point_queue[$];
    t_normal     normal_due[$];
    int          cycles = 0;
    int          errors = 0;
    int          rand_points = 0;
    logic        word_taken = 1'b0;
    logic        calm = 1'b0;

    // predictor state
    logic [pcne_pkg::CFG_W-1:0] cfg_w = pcne_pkg::WIDTH_RST;
    logic [pcne_pkg::CFG_W-1:0] cfg_h = pcne_pkg::HEIGHT_RST;
    t_point line_near[BUF_DEPTH];
    t_point line_far[BUF_DEPTH];
    t_point win[6];
    int     col_cnt = 0;
    int     row_cnt = 0;

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 30; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_part(longint v, int s, longint unsigned q);
        longint unsigned a;
        longint unsigned u;
        a = magnitude(v) >> s;
        u = (a * 32768 + q) / (2 * q);
        return (v < 0) ? 16'(-u) : 16'(u);
    endfunction

    function automatic logic is_origin(t_point p);
        return p.x == 0 && p.y == 0 && p.z == 0;
    endfunction

    task automatic estimate_normal(t_point cur, logic sof);
        int w, h, c, r, s;
        t_point top, mid, tl, tr, dl;
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint unsigned m, a0, a1, a2, q;
        t_normal n;
        w = (cfg_w < 3) ? 3 : (cfg_w > BUF_DEPTH) ? BUF_DEPTH : cfg_w;
        h = (cfg_h < 3) ? 3 : (cfg_h > pcne_pkg::MAX_HEIGHT) ? pcne_pkg::MAX_HEIGHT : cfg_h;
        if (sof) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c = col_cnt % BUF_DEPTH;
        r = row_cnt;
        top = line_far[c];
        mid = line_near[c];
        line_far[c] = mid;
        line_near[c] = cur;
        tl = win[1];
        tr = top;
        dl = win[5];
        win[1] = win[0]; win[0] = top;
        win[3] = win[2]; win[2] = mid;
        win[5] = win[4]; win[4] = cur;
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        if (!(r >= 2 && c >= 2 && r < h && c < w)) return;
        n = '0;
        n.row = 10'(r - 1);
        n.col = 10'(c - 1);
        if (!is_origin(tl) && !is_origin(tr) && !is_origin(dl) && !is_origin(cur)) begin
            ax = longint'(tl.x) - longint'(cur.x);
            ay = longint'(tl.y) - longint'(cur.y);
            az = longint'(tl.z) - longint'(cur.z);
            bx = longint'(tr.x) - longint'(dl.x);
            by = longint'(tr.y) - longint'(dl.y);
            bz = longint'(tr.z) - longint'(dl.z);
            cx = ay * bz - az * by;
            cy = az * bx - ax * bz;
            cz = ax * by - ay * bx;
            if (cz < 0) begin
                cx = -cx; cy = -cy; cz = -cz;
            end
            m = magnitude(cx);
            if (magnitude(cy) > m) m = magnitude(cy);
            if (magnitude(cz) > m) m = magnitude(cz);
            if (m != 0) begin
                s = 0;
                while ((m >> s) >= (64'd1 << 30)) s++;
                a0 = magnitude(cx) >> s;
                a1 = magnitude(cy) >> s;
                a2 = magnitude(cz) >> s;
                q = root_floor(a0 * a0 + a1 * a1 + a2 * a2);
                n.nx = unit_part(cx, s, q);
                n.ny = unit_part(cy, s, q);
                n.nz = 15'(unit_part(cz, s, q));
            end
        end
        normal_due.push_back(n);
    endtask

    // predict accepted words, check output words
    always @(posedge i_clk) begin
        t_normal e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("point_cloud_normal_estimator verification failed");
            $finish;
        end
        word_taken <= i_valid && !o_stall;
        if (i_rst_n && i_cfg_we) begin
            if (i_cfg_idx == pcne_pkg::CFG_WIDTH) cfg_w = i_cfg_data;
            else cfg_h = i_cfg_data;
        end
        if (i_rst_n && i_valid && !o_stall)
            estimate_normal({i_point_x, i_point_y, i_point_z}, i_start_of_frame);
        if (i_rst_n && o_valid && !i_stall) begin
            if (normal_due.size() == 0) begin
                $display("%0t: unexpected normal word row %0d col %0d", $time,
                         o_center_row, o_center_col);
                errors++;
            end else begin
                e = normal_due.pop_front();
                if (o_normal_x !== e.nx || o_normal_y !== e.ny || o_normal_z !== e.nz
                    || o_center_valid !== 1'b1 || o_center_row !== e.row
                    || o_center_col !== e.col) begin
                    $display("%0t: expected n=(%0d,%0d,%0d) v=1 at (%0d,%0d), got n=(%0d,%0d,%0d) v=%0b at (%0d,%0d)",
                             $time, $signed(e.nx), $signed(e.ny), e.nz, e.row, e.col,
                             o_normal_x, o_normal_y, o_normal_z, o_center_valid,
                             o_center_row, o_center_col);
                    errors++;
                end
            end
        end
    end

    // point driver: advance on acceptance, idle at random
    always @(negedge i_clk) begin
        t_point_word pw;
        if (i_rst_n && (!i_valid || word_taken)) begin
            if (point_queue.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
                pw = point_queue.pop_front();
                i_point_x <= pw.pt.x;
                i_point_y <= pw.pt.y;
                i_point_z <= pw.pt.z;
                i_start_of_frame <= pw.sof;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk)
        i_stall <= !calm && ($urandom_range(99) < 33);

    task automatic add_point(int x, int y, int z, logic sof);
        t_point_word pw;
        pw.pt.x = 16'(x);
        pw.pt.y = 16'(y);
        pw.pt.z = 16'(z);
        pw.sof = sof;
        point_queue.push_back(pw);
    endtask

    task automatic configure(int w, int h);
        while (point_queue.size() != 0 || i_valid || normal_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= pcne_pkg::CFG_WIDTH;
        i_cfg_data <= pcne_pkg::CFG_W'(w);
        @(negedge i_clk);
        i_cfg_idx <= pcne_pkg::CFG_HEIGHT;
        i_cfg_data <= pcne_pkg::CFG_W'(h);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // smooth surface words with random content, plus noise and holes
    task automatic fill_frame(int w, int n, logic sof_first);
        int step, slope_a, slope_b, base, kind, c, r, v;
        step = $urandom_range(400, 16);
        slope_a = $urandom_range(60) - 30;
        slope_b = $urandom_range(60) - 30;
        base = $urandom_range(20000) - 10000;
        v = $urandom;
        for (int k = 0; k < n; k++) begin
            c = k % w;
            r = k / w;
            kind = $urandom_range(99);
            if (kind < 65)
                add_point(c * step + $urandom_range(6) - 3, r * step + $urandom_range(6) - 3,
                          base + slope_a * c + slope_b * r + $urandom_range(4) - 2,
                          (k == 0 && sof_first) || $urandom_range(199) == 0);
            else if (kind < 80)
                add_point($urandom, $urandom, $urandom, (k == 0 && sof_first));
            else if (kind < 85)
                add_point(0, 0, 0, (k == 0 && sof_first));
            else if (kind < 92)
                add_point(v, v >> 8, v >> 16, (k == 0 && sof_first));
            else
                add_point($urandom_range(16) - 8, $urandom_range(16) - 8,
                          $urandom_range(16) - 8, (k == 0 && sof_first));
        end
    endtask

    initial begin
        int w, h, n;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(5, 4);
        add_point(32767, -32768, 32767, 1'b1);
        add_point(-32768, 32767, -32768, 1'b0);
        add_point(100, 200, 300, 1'b0);
        add_point(1, 1, 1, 1'b0);
        add_point(32767, 32767, 32767, 1'b0);
        add_point(-1, -1, -1, 1'b0);
        add_point(4096, 0, 0, 1'b0);
        add_point(0, 4096, 0, 1'b0);
        add_point(0, 0, 4096, 1'b0);
        add_point(-32768, -32768, -32768, 1'b0);
        add_point(-32768, 32767, 32767, 1'b0);
        add_point(0, 0, 0, 1'b0);
        add_point(32767, -32768, -32768, 1'b0);
        add_point(4096, 4096, -4096, 1'b0);
        add_point(-4096, 4096, 4096, 1'b0);
        add_point(32767, -32768, 32767, 1'b0);
        add_point(200, 400, 600, 1'b0);
        add_point(-32768, 32767, -32768, 1'b0);
        add_point(2, 2, 2, 1'b0);
        add_point(3, 3, 3, 1'b0);

        configure(3, 3);
        fill_frame(3, 12, 1'b1);
        configure(2047, 3);
        fill_frame(1024, 40, 1'b1);
        configure(0, 2047);
        fill_frame(3, 3 * 40 + 2, 1'b1);
        configure(1024, 1024);
        fill_frame(1024, 40, 1'b1);
        // shrink the row without a frame start: stale column count
        configure(12, 5);
        fill_frame(12, 55, 1'b1);
        configure(4, 5);
        fill_frame(4, 30, 1'b0);
        configure(1, 0);
        fill_frame(3, 20, 1'b1);

        calm <= 1'b1;
        while (rand_points < 700) begin
            w = $urandom_range(16, 3);
            h = $urandom_range(8, 3);
            n = w * h * $urandom_range(3, 1) + $urandom_range(w);
            configure(($urandom_range(9) == 0) ? $urandom_range(2) : w, h);
            if (rand_points >= 300) calm <= 1'b0;
            fill_frame(w, n, 1'b1);
            rand_points += n;
        end

        while (point_queue.size() != 0 || i_valid || normal_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (errors == 0)
            $display("point_cloud_normal_estimator verification clean");
        else
            $display("point_cloud_normal_estimator verification failed");
        $finish;
    end
endmodule
